### rtl/core/cpuoa_pkg.sv
// cpuoa_pkg: opcodes, sequencer states and decode types of the operand addressing unit
// no dependencies; used by cpu_operand_addressing_unit
package cpuoa_pkg;

  typedef enum logic [3:0] {
    OP_LD_IMM  = 4'd0,
    OP_LD_ZP   = 4'd1,
    OP_LD_ZPX  = 4'd2,
    OP_LD_ZPY  = 4'd3,
    OP_LD_ABS  = 4'd4,
    OP_LD_ABSX = 4'd5,
    OP_LD_ABSY = 4'd6,
    OP_LD_INDX = 4'd7,
    OP_LD_INDY = 4'd8,
    OP_ST_ZP   = 4'd9,
    OP_ST_ZPX  = 4'd10,
    OP_ST_ABS  = 4'd11,
    OP_ST_INDX = 4'd12,
    OP_ST_INDY = 4'd13,
    OP_PUSH    = 4'd14,
    OP_PULL    = 4'd15
  } opcode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PTR_LO,
    S_PTR_HI,
    S_ADDR,
    S_ACCESS,
    S_RESP
  } state_t;

  localparam int BYTE_BITS = 8;
  localparam int EA_BITS = 16;
  localparam logic [7:0] SP_RESET = 8'hFF;
  localparam logic [7:0] SP_FULL = 8'h00;
  localparam logic [7:0] SP_EMPTY = 8'hFF;
  localparam logic [7:0] STACK_PAGE = 8'h01;

  typedef struct packed {
    logic       access;
    logic       write;
    logic       rd_mem;
    logic       indirect;
    logic       add_y;
    logic       fault;
    logic [7:0] imm;
    logic [7:0] ptr;
    logic [7:0] sp;
  } decode_t;

  typedef struct packed {
    logic we;
    logic valid;
    logic busy;
  } ctrl_t;

endpackage

### rtl/core/cpu_operand_addressing_unit.sv
// cpu_operand_addressing_unit: top level, sequencer around one single-port byte memory
// depends on cpuoa_pkg and cpuoa_ram
//
// usage: a transaction is accepted when start is high and busy is low; the
// opcode, operand bytes, index values and store byte are sampled on in_*.
// busy stays high until the result has been shown. exactly one result per
// transaction appears on out_* for one cycle, marked by out_valid; the
// receiver cannot stall and must take it in that cycle.
// states from the accepting edge to the out_valid state S_RESP:
//   immediate and refused stack operations: S_RESP directly
//   zero page, absolute, indexed, push and pull: S_ACCESS, S_RESP
//   indirect modes: S_PTR_LO, S_PTR_HI, S_ADDR, S_ACCESS, S_RESP
// a new transaction can be accepted in the cycle after out_valid, so the unit
// takes no new transaction before it is through with the last one; the single
// memory port carries one pointer read, data read or write per cycle and has
// registered read data. reset returns the sequencer to idle and the stack
// pointer to 0xff; memory contents are undefined until written.
module cpu_operand_addressing_unit #(
  parameter int ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_opcode,
  input  logic [7:0]  in_operand_low,
  input  logic [7:0]  in_operand_high,
  input  logic [7:0]  in_x_index,
  input  logic [7:0]  in_y_index,
  input  logic [7:0]  in_store_data,
  output logic        out_valid,
  output logic [7:0]  out_read_data,
  output logic [15:0] out_effective_address,
  output logic        out_stack_fault,
  output logic [7:0]  out_stack_pointer_now
);

  cpuoa_pkg::state_t state_r, state_nxt;
  cpuoa_pkg::decode_t dec;
  cpuoa_pkg::ctrl_t ctrl;

  logic [7:0]           sp_r;
  logic [ADDR_BITS-1:0] ea_r, ea_nxt;
  logic [7:0]           ptr_r, ptr_lo_r, imm_r, wdata_r, y_r;
  logic [7:0]           ptr_inc;
  logic                 we_r, rd_mem_r, add_y_r, fault_r;
  logic [ADDR_BITS-1:0] ram_addr;
  logic [7:0]           ram_rdata;
  logic                 accept;

  assign accept = start && !busy;

  // second pointer byte wraps inside page zero
  assign ptr_inc = ptr_r + 8'd1;

  // decode of the incoming transaction
  always_comb begin
    logic [7:0]  zpx, zpy, sp_inc;
    logic [15:0] absw;
    zpx = in_operand_low + in_x_index;
    zpy = in_operand_low + in_y_index;
    absw = {in_operand_high, in_operand_low};
    sp_inc = sp_r + 8'd1;
    dec = '0;
    dec.sp = sp_r;
    ea_nxt = '0;
    unique case (cpuoa_pkg::opcode_t'(in_opcode))
      cpuoa_pkg::OP_LD_IMM: begin
        dec.imm = in_operand_low;
      end
      cpuoa_pkg::OP_LD_ZP, cpuoa_pkg::OP_ST_ZP: begin
        dec.access = 1'b1;
        ea_nxt = ADDR_BITS'(in_operand_low);
      end
      cpuoa_pkg::OP_LD_ZPX, cpuoa_pkg::OP_ST_ZPX: begin
        dec.access = 1'b1;
        ea_nxt = ADDR_BITS'(zpx);
      end
      cpuoa_pkg::OP_LD_ZPY: begin
        dec.access = 1'b1;
        ea_nxt = ADDR_BITS'(zpy);
      end
      cpuoa_pkg::OP_LD_ABS, cpuoa_pkg::OP_ST_ABS: begin
        dec.access = 1'b1;
        ea_nxt = ADDR_BITS'(absw);
      end
      cpuoa_pkg::OP_LD_ABSX: begin
        dec.access = 1'b1;
        ea_nxt = ADDR_BITS'(absw + 16'(in_x_index));
      end
      cpuoa_pkg::OP_LD_ABSY: begin
        dec.access = 1'b1;
        ea_nxt = ADDR_BITS'(absw + 16'(in_y_index));
      end
      cpuoa_pkg::OP_LD_INDX, cpuoa_pkg::OP_ST_INDX: begin
        dec.indirect = 1'b1;
        dec.ptr = zpx;
      end
      cpuoa_pkg::OP_LD_INDY, cpuoa_pkg::OP_ST_INDY: begin
        dec.indirect = 1'b1;
        dec.add_y = 1'b1;
        dec.ptr = in_operand_low;
      end
      cpuoa_pkg::OP_PUSH: begin
        if (sp_r == cpuoa_pkg::SP_FULL) begin
          dec.fault = 1'b1;
        end else begin
          dec.access = 1'b1;
          dec.write = 1'b1;
          ea_nxt = ADDR_BITS'({cpuoa_pkg::STACK_PAGE, sp_r});
          dec.sp = sp_r - 8'd1;
        end
      end
      cpuoa_pkg::OP_PULL: begin
        if (sp_r == cpuoa_pkg::SP_EMPTY) begin
          dec.fault = 1'b1;
        end else begin
          dec.access = 1'b1;
          ea_nxt = ADDR_BITS'({cpuoa_pkg::STACK_PAGE, sp_inc});
          dec.sp = sp_inc;
        end
      end
      default: begin
        dec.fault = 1'b0;
      end
    endcase
    unique case (cpuoa_pkg::opcode_t'(in_opcode))
      cpuoa_pkg::OP_ST_ZP, cpuoa_pkg::OP_ST_ZPX, cpuoa_pkg::OP_ST_ABS,
      cpuoa_pkg::OP_ST_INDX, cpuoa_pkg::OP_ST_INDY: begin
        dec.write = 1'b1;
      end
      cpuoa_pkg::OP_LD_ZP, cpuoa_pkg::OP_LD_ZPX, cpuoa_pkg::OP_LD_ZPY,
      cpuoa_pkg::OP_LD_ABS, cpuoa_pkg::OP_LD_ABSX, cpuoa_pkg::OP_LD_ABSY,
      cpuoa_pkg::OP_LD_INDX, cpuoa_pkg::OP_LD_INDY: begin
        dec.rd_mem = 1'b1;
      end
      cpuoa_pkg::OP_PULL: begin
        dec.rd_mem = !dec.fault;
      end
      default: begin
        dec.rd_mem = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cpuoa_pkg::S_IDLE: begin
        if (start) begin
          if (dec.indirect) begin
            state_nxt = cpuoa_pkg::S_PTR_LO;
          end else if (dec.access) begin
            state_nxt = cpuoa_pkg::S_ACCESS;
          end else begin
            state_nxt = cpuoa_pkg::S_RESP;
          end
        end
      end
      cpuoa_pkg::S_PTR_LO: state_nxt = cpuoa_pkg::S_PTR_HI;
      cpuoa_pkg::S_PTR_HI: state_nxt = cpuoa_pkg::S_ADDR;
      cpuoa_pkg::S_ADDR:   state_nxt = cpuoa_pkg::S_ACCESS;
      cpuoa_pkg::S_ACCESS: state_nxt = cpuoa_pkg::S_RESP;
      cpuoa_pkg::S_RESP:   state_nxt = cpuoa_pkg::S_IDLE;
      default:             state_nxt = cpuoa_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ctrl = '0;
    ram_addr = ea_r;
    unique case (state_r)
      cpuoa_pkg::S_IDLE: begin
        ctrl.busy = 1'b0;
      end
      cpuoa_pkg::S_PTR_LO: begin
        ctrl.busy = 1'b1;
        ram_addr = ADDR_BITS'(ptr_r);
      end
      cpuoa_pkg::S_PTR_HI: begin
        ctrl.busy = 1'b1;
        ram_addr = ADDR_BITS'(ptr_inc);
      end
      cpuoa_pkg::S_ADDR: begin
        ctrl.busy = 1'b1;
      end
      cpuoa_pkg::S_ACCESS: begin
        ctrl.busy = 1'b1;
        ctrl.we = we_r;
      end
      cpuoa_pkg::S_RESP: begin
        ctrl.busy = 1'b1;
        ctrl.valid = 1'b1;
      end
      default: begin
        ctrl.busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cpuoa_pkg::S_IDLE;
      sp_r <= cpuoa_pkg::SP_RESET;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        sp_r <= dec.sp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ea_r <= ea_nxt;
      ptr_r <= dec.ptr;
      imm_r <= dec.imm;
      wdata_r <= in_store_data;
      y_r <= in_y_index;
      we_r <= dec.write;
      rd_mem_r <= dec.rd_mem;
      add_y_r <= dec.add_y;
      fault_r <= dec.fault;
    end
    if (state_r == cpuoa_pkg::S_PTR_HI) begin
      ptr_lo_r <= ram_rdata;
    end
    if (state_r == cpuoa_pkg::S_ADDR) begin
      ea_r <= ADDR_BITS'({ram_rdata, ptr_lo_r} + (add_y_r ? 16'(y_r) : 16'd0));
    end
  end

  cpuoa_ram #(
    .ADDR_BITS(ADDR_BITS)
  ) u_ram (
    .clk  (clk),
    .we   (ctrl.we),
    .addr (ram_addr),
    .wdata(wdata_r),
    .rdata(ram_rdata)
  );

  assign busy = ctrl.busy;
  assign out_valid = ctrl.valid;
  assign out_read_data = rd_mem_r ? ram_rdata : imm_r;
  assign out_effective_address = 16'(ea_r);
  assign out_stack_fault = fault_r;
  assign out_stack_pointer_now = sp_r;

endmodule

### rtl/core/cpuoa_ram.sv
// cpuoa_ram: single-port byte memory with registered read data
// no dependencies; instantiated by cpu_operand_addressing_unit
module cpuoa_ram #(
  parameter int ADDR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [7:0]           wdata,
  output logic [7:0]           rdata
);

  logic [7:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/core/cpuoa_checker.sv
// cpuoa_port_props: port-level assertions for cpu_operand_addressing_unit
// depends on cpu_operand_addressing_unit; bound to it at the end of this file
module cpuoa_port_props (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [7:0]  out_read_data,
  input logic [15:0] out_effective_address,
  input logic        out_stack_fault
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("not idle after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("transaction accepted but unit not busy");

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result shown outside a transaction");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe longer than one cycle");

  a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stack_fault) |->
      (out_read_data == 8'd0) && (out_effective_address == 16'd0))
    else $error("refused stack transaction with nonzero data or address");

endmodule

bind cpu_operand_addressing_unit cpuoa_port_props u_cpuoa_port_props (
  .clk                  (clk),
  .rst_n                (rst_n),
  .start                (start),
  .busy                 (busy),
  .out_valid            (out_valid),
  .out_read_data        (out_read_data),
  .out_effective_address(out_effective_address),
  .out_stack_fault      (out_stack_fault)
);
